@@ hdl/ecu_pkg.sv @@
package ecu_pkg;

    // Number formats and table geometry.
    localparam int FRAC_BITS       = 16;
    localparam int TABLE_ADDR_BITS = 8;
    localparam int SEGS            = 1 << TABLE_ADDR_BITS;
    localparam int ONE             = 1 << FRAC_BITS;
    localparam int PROG_W          = FRAC_BITS + 1;
    localparam int OUT_W           = FRAC_BITS + 2;
    localparam int VAL_W           = FRAC_BITS + 4;

    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint LN2_Q30     = 64'sd744261118;

    typedef logic [PROG_W-1:0]              frac_t;
    typedef logic [SEGS:0][PROG_W-1:0]      tab_t;
    typedef logic signed [VAL_W-1:0]        val_t;

    localparam frac_t ONE_F = frac_t'(ONE);

    // Easing modes.
    typedef enum logic [3:0] {
        MODE_LINEAR,
        MODE_QUAD_IN,
        MODE_QUAD_OUT,
        MODE_QUAD_INOUT,
        MODE_CUBIC_IN,
        MODE_CUBIC_OUT,
        MODE_CUBIC_INOUT,
        MODE_SINE_IN,
        MODE_SINE_OUT,
        MODE_SINE_INOUT,
        MODE_BOUNCE_IN,
        MODE_BOUNCE_OUT,
        MODE_BOUNCE_INOUT,
        MODE_ELASTIC_IN,
        MODE_ELASTIC_OUT,
        MODE_ELASTIC_INOUT
    } mode_t;

    // Per-item control that travels down the pipeline.
    typedef struct packed {
        mode_t op;
        logic  low;
        logic  at_zero;
        logic  at_one;
        frac_t t;
    } ctl_t;

    // Round a non-negative Q30 value to the output fraction, capped at one.
    function automatic frac_t q30_to_frac(longint v);
        longint r;
        r = (v + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
        return (r > ONE) ? ONE_F : frac_t'(r);
    endfunction

    // Truncated quotient of two non-negative values by shift and subtract.
    function automatic longint div_floor(longint num, longint den);
        longint q;
        longint r;
        q = 64'sd0;
        r = 64'sd0;
        for (int i = 62; i >= 0; i--) begin
            r = (r <<< 1) | ((num >>> i) & 64'sd1);
            q = q <<< 1;
            if (r >= den) begin
                r = r - den;
                q = q | 64'sd1;
            end
        end
        return q;
    endfunction

    // Quarter-wave sine table from a truncated Taylor series.
    function automatic tab_t build_sin();
        tab_t   tab;
        longint x;
        longint x2;
        longint term;
        longint sum;
        for (int k = 0; k <= SEGS; k++) begin
            x  = (longint'(k) * HALF_PI_Q30 + longint'(SEGS / 2)) >>> TABLE_ADDR_BITS;
            x2 = (x * x + (64'sd1 <<< 29)) >>> 30;
            term = x;
            sum  = x;
            for (int n = 1; n <= 7; n++) begin
                term = div_floor((term * x2) >>> 30, longint'((2 * n) * (2 * n + 1)));
                sum  = ((n % 2) == 1) ? sum - term : sum + term;
            end
            tab[k] = q30_to_frac((sum < 0) ? 64'sd0 : sum);
        end
        return tab;
    endfunction

    // Table of 2^-x over one octave.
    function automatic tab_t build_exp();
        tab_t   tab;
        longint y;
        longint term;
        longint sum;
        for (int k = 0; k <= SEGS; k++) begin
            y    = (longint'(k) * LN2_Q30 + longint'(SEGS / 2)) >>> TABLE_ADDR_BITS;
            term = 64'sd1 <<< 30;
            sum  = term;
            for (int n = 1; n <= 12; n++) begin
                term = div_floor((term * y) >>> 30, longint'(n));
                sum  = ((n % 2) == 1) ? sum - term : sum + term;
            end
            tab[k] = q30_to_frac((sum < 0) ? 64'sd0 : sum);
        end
        return tab;
    endfunction

    localparam tab_t SIN_TAB = build_sin();
    localparam tab_t EXP_TAB = build_exp();

endpackage

@@ hdl/ecu_lookup.sv @@
module ecu_lookup
    import ecu_pkg::*;
(
    input  logic  aclk,
    input  logic  en,
    input  logic  use_exp,
    input  frac_t p,
    output frac_t value
);

    logic [TABLE_ADDR_BITS:0]   k;
    logic [TABLE_ADDR_BITS:0]   k_hi;
    frac_t                      frac;
    frac_t                      lo_reg;
    frac_t                      hi_reg;
    frac_t                      frac_reg;
    frac_t                      value_reg;
    frac_t                      value_next;
    logic signed [PROG_W:0]     diff;
    logic signed [2*PROG_W+1:0] prod;
    logic signed [2*PROG_W+1:0] rnd;

    // Segment index and position inside it; the end point uses the last segment.
    always_comb begin
        if (p[FRAC_BITS]) begin
            k    = (TABLE_ADDR_BITS + 1)'(SEGS - 1);
            frac = ONE_F;
        end else begin
            k    = {1'b0, p[FRAC_BITS-1 -: TABLE_ADDR_BITS]};
            frac = {1'b0, p[FRAC_BITS-TABLE_ADDR_BITS-1:0], {TABLE_ADDR_BITS{1'b0}}};
        end
        k_hi = k + 1'b1;
    end

    // Stage one: read both neighbors.
    always_ff @(posedge aclk) begin
        if (en) begin
            lo_reg   <= use_exp ? EXP_TAB[k] : SIN_TAB[k];
            hi_reg   <= use_exp ? EXP_TAB[k_hi] : SIN_TAB[k_hi];
            frac_reg <= frac;
        end
    end

    // Stage two: linear interpolation, rounded half away from zero.
    always_comb begin
        diff = $signed({1'b0, hi_reg}) - $signed({1'b0, lo_reg});
        prod = diff * $signed({1'b0, frac_reg});
        if (prod >= 0) begin
            rnd = (prod + (1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        end else begin
            rnd = -((-prod + (1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
        end
        value_next = frac_t'($signed({1'b0, lo_reg}) + rnd);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

@@ hdl/easing_curve_unit.sv @@
// Channel   Ports                               Content
// input     s_valid s_ready s_operation s_progress  mode, progress in Q1.16
// result    m_valid m_ready m_eased_value       eased value in Q2.16, saturated
//
// Eight register stages; one item enters per cycle unless the result side stalls.
// The elastic path (product, cosine lookup, final product) sets the depth. A stall
// on the result side holds every stage at once, and s_ready follows it. Reset
// clears only the valid bits.
module easing_curve_unit
    import ecu_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [3:0]              s_operation,
    input  logic [PROG_W-1:0]       s_progress,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [OUT_W-1:0] m_eased_value
);

    localparam int    NSTG  = 8;
    localparam int    REC_S = 24;
    localparam longint REC_K = ((64'sd1 <<< REC_S) + 2) / 3;
    localparam val_t  ONE_V  = val_t'(ONE);
    localparam val_t  HALF_V = val_t'(ONE / 2);

    function automatic val_t half_rnd(val_t v);
        return (v >= 0) ? ((v + val_t'(1)) >>> 1) : -((-v + val_t'(1)) >>> 1);
    endfunction

    logic en;
    logic [NSTG:1] v_reg;
    ctl_t ctl_reg [1:NSTG-1];
    ctl_t ctl_in;

    assign en      = !m_valid || m_ready;
    assign s_ready = en;
    assign m_valid = v_reg[NSTG];

    // Clamp progress and decode the flags the later stages need.
    always_comb begin
        ctl_in.op      = mode_t'(s_operation);
        ctl_in.t       = (s_progress > ONE_F) ? ONE_F : s_progress;
        ctl_in.low     = ctl_in.t < frac_t'(ONE / 2);
        ctl_in.at_zero = ctl_in.t == '0;
        ctl_in.at_one  = ctl_in.t == ONE_F;
    end

    // Valid bits and control travel together.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NSTG-1:1], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl_reg[1] <= ctl_in;
            for (int i = 2; i < NSTG; i++) begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
        end
    end

    // Stage 2: operand selection.
    frac_t            d1;
    logic [PROG_W:0]  t2x;
    frac_t            a_next, u_next, a2_reg, u2_reg, a3_reg;
    logic [PROG_W:0]  b_next, sph_next, b2_reg, sph2_reg;

    always_comb begin
        d1       = ONE_F - ctl_reg[1].t;
        t2x      = {ctl_reg[1].t, 1'b0};
        a_next   = ctl_reg[1].t;
        b_next   = {1'b0, ctl_reg[1].t};
        u_next   = ctl_reg[1].t;
        sph_next = {1'b0, ctl_reg[1].t};
        if (ctl_reg[1].op inside {MODE_QUAD_INOUT, MODE_CUBIC_INOUT}) begin
            a_next = ctl_reg[1].low ? ctl_reg[1].t : d1;
        end else if (ctl_reg[1].op == MODE_CUBIC_OUT) begin
            a_next = d1;
        end
        if (ctl_reg[1].op == MODE_QUAD_OUT) begin
            b_next = (PROG_W + 1)'(2 * ONE) - {1'b0, ctl_reg[1].t};
        end else begin
            b_next = {1'b0, a_next};
        end
        if (ctl_reg[1].op inside {MODE_BOUNCE_IN, MODE_ELASTIC_IN}) begin
            u_next = d1;
        end else if (ctl_reg[1].op inside {MODE_BOUNCE_INOUT, MODE_ELASTIC_INOUT}) begin
            u_next = ctl_reg[1].low ? frac_t'((PROG_W + 1)'(ONE) - t2x)
                                    : frac_t'(t2x - (PROG_W + 1)'(ONE));
        end
        if (ctl_reg[1].op == MODE_SINE_IN) begin
            sph_next = {1'b0, ctl_reg[1].t} + (PROG_W + 1)'(ONE);
        end else if (ctl_reg[1].op == MODE_SINE_INOUT) begin
            sph_next = t2x + (PROG_W + 1)'(ONE);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a2_reg   <= a_next;
            b2_reg   <= b_next;
            u2_reg   <= u_next;
            sph2_reg <= sph_next;
        end
    end

    // Stage 3: first product, bounce segment, elastic phase and exponent.
    logic [2*PROG_W:0]      p1_reg;
    logic [PROG_W+2:0]      w3;
    logic signed [PROG_W+3:0] x_next, x3_reg;
    frac_t                  base_next, base3_reg, base4_reg;
    logic [PROG_W+4:0]      n_next, n3_reg;
    logic [PROG_W+2:0]      e10;
    logic [3:0]             ie3_reg, ie4_reg;
    logic                   neg3_reg, neg4_reg;
    frac_t                  sin_p, exp_p, sin_v, exp_v;

    always_comb begin
        w3 = (PROG_W + 3)'(u2_reg) * (PROG_W + 3)'(11);
        if (w3 < (PROG_W + 3)'(4 * ONE)) begin
            x_next    = $signed({1'b0, w3});
            base_next = '0;
        end else if (w3 < (PROG_W + 3)'(8 * ONE)) begin
            x_next    = $signed({1'b0, w3}) - (PROG_W + 4)'(6 * ONE);
            base_next = frac_t'(3 * ONE / 4);
        end else if (w3 < (PROG_W + 3)'(10 * ONE)) begin
            x_next    = $signed({1'b0, w3}) - (PROG_W + 4)'(9 * ONE);
            base_next = frac_t'(15 * ONE / 16);
        end else begin
            x_next    = $signed({1'b0, w3}) - (PROG_W + 4)'(21 * ONE / 2);
            base_next = frac_t'(63 * ONE / 64);
        end
        n_next = (PROG_W + 5)'(u2_reg) * (PROG_W + 5)'(40) + 1'b1;
        e10    = (PROG_W + 3)'(u2_reg) * (PROG_W + 3)'(10);
        exp_p  = {1'b0, e10[FRAC_BITS-1:0]};
        sin_p  = sph2_reg[FRAC_BITS] ? ONE_F - {1'b0, sph2_reg[FRAC_BITS-1:0]}
                                     : {1'b0, sph2_reg[FRAC_BITS-1:0]};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg    <= (2 * PROG_W + 1)'(a2_reg) * (2 * PROG_W + 1)'(b2_reg);
            a3_reg    <= a2_reg;
            x3_reg    <= x_next;
            base3_reg <= base_next;
            n3_reg    <= n_next;
            ie3_reg   <= e10[FRAC_BITS+3:FRAC_BITS];
            neg3_reg  <= sph2_reg[FRAC_BITS+1];
        end
    end

    ecu_lookup u_sin (
        .aclk    (aclk),
        .en      (en),
        .use_exp (1'b0),
        .p       (sin_p),
        .value   (sin_v)
    );

    ecu_lookup u_exp (
        .aclk    (aclk),
        .en      (en),
        .use_exp (1'b1),
        .p       (exp_p),
        .value   (exp_v)
    );

    // Stage 4: rounding of the first product, cube product, square, phase division.
    logic [PROG_W:0]        m1_next, m1_4_reg;
    logic [2*PROG_W+1:0]    p2_4_reg;
    logic [2*PROG_W+3:0]    xx4_reg;
    logic [PROG_W+28:0]     prod4_reg;

    always_comb begin
        m1_next = (PROG_W + 1)'((p1_reg + (2 * PROG_W + 1)'(ONE / 2)) >> FRAC_BITS);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m1_4_reg  <= m1_next;
            p2_4_reg  <= (2 * PROG_W + 2)'(m1_next) * (2 * PROG_W + 2)'(a3_reg);
            xx4_reg   <= (2 * PROG_W + 4)'(x3_reg * x3_reg);
            base4_reg <= base3_reg;
            prod4_reg <= (PROG_W + 29)'(n3_reg) * (PROG_W + 29)'(REC_K);
            ie4_reg   <= ie3_reg;
            neg4_reg  <= neg3_reg;
        end
    end

    // Stage 5: finish polynomial, bounce and sine curves; cosine lookup; power shift.
    logic [PROG_W:0]    m2;
    logic [PROG_W+4:0]  cq;
    logic [1:0]         cq_quad;
    frac_t              cos_p, cos_v;
    val_t               m1v, m2v, bo, sv, res_next, res5_reg, res6_reg, res7_reg;
    logic [PROG_W:0]    rnd_pw, pw_next, pw5_reg, pw6_reg;
    logic               negc5_reg, negc6_reg;

    always_comb begin
        m2  = (PROG_W + 1)'((p2_4_reg + (2 * PROG_W + 2)'(ONE / 2)) >> FRAC_BITS);
        m1v = val_t'(m1_4_reg);
        m2v = val_t'(m2);
        bo  = val_t'(base4_reg) + val_t'((xx4_reg + (2 * PROG_W + 4)'(1 << (FRAC_BITS + 3)))
                                          >> (FRAC_BITS + 4));
        sv  = neg4_reg ? -val_t'(sin_v) : val_t'(sin_v);
        case (ctl_reg[4].op)
            MODE_LINEAR:       res_next = val_t'(ctl_reg[4].t);
            MODE_QUAD_IN:      res_next = m1v;
            MODE_QUAD_OUT:     res_next = m1v;
            MODE_QUAD_INOUT:   res_next = ctl_reg[4].low ? (m1v <<< 1) : ONE_V - (m1v <<< 1);
            MODE_CUBIC_IN:     res_next = m2v;
            MODE_CUBIC_OUT:    res_next = ONE_V - m2v;
            MODE_CUBIC_INOUT:  res_next = ctl_reg[4].low ? (m2v <<< 2) : ONE_V - (m2v <<< 2);
            MODE_SINE_IN:      res_next = ONE_V - sv;
            MODE_SINE_OUT:     res_next = sv;
            MODE_SINE_INOUT:   res_next = half_rnd(ONE_V - sv);
            MODE_BOUNCE_IN:    res_next = ONE_V - bo;
            MODE_BOUNCE_OUT:   res_next = bo;
            MODE_BOUNCE_INOUT: res_next = ctl_reg[4].low ? half_rnd(ONE_V - bo)
                                                         : half_rnd(bo) + HALF_V;
            default:           res_next = '0;
        endcase

        // Cosine phase: floor((40d + 1) / 3) quarter turns plus one quarter turn.
        cq      = prod4_reg[PROG_W+28:REC_S];
        cq_quad = cq[FRAC_BITS+1:FRAC_BITS] + 2'd1;
        cos_p   = cq_quad[0] ? ONE_F - {1'b0, cq[FRAC_BITS-1:0]} : {1'b0, cq[FRAC_BITS-1:0]};

        // 2^-e: table value of the fraction, shifted by the integer part with rounding.
        rnd_pw  = ((PROG_W + 1)'(1) << ie4_reg) >> 1;
        pw_next = ((PROG_W + 1)'(exp_v) + rnd_pw) >> ie4_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res5_reg  <= res_next;
            pw5_reg   <= pw_next;
            negc5_reg <= cq_quad[1];
            res6_reg  <= res5_reg;
            pw6_reg   <= pw5_reg;
            negc6_reg <= negc5_reg;
        end
    end

    ecu_lookup u_cos (
        .aclk    (aclk),
        .en      (en),
        .use_exp (1'b0),
        .p       (cos_p),
        .value   (cos_v)
    );

    // Stage 7: damping times cosine.
    logic signed [PROG_W:0]     cvs;
    logic signed [2*PROG_W+2:0] prod7_reg;

    always_comb begin
        cvs = negc6_reg ? -$signed({1'b0, cos_v}) : $signed({1'b0, cos_v});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod7_reg <= $signed({1'b0, pw6_reg}) * cvs;
            res7_reg  <= res6_reg;
        end
    end

    // Stage 8: elastic forms, end points and saturation.
    logic signed [2*PROG_W+2:0] core_w;
    val_t                       core, ela, fin;
    logic signed [OUT_W-1:0]    out_reg;
    logic signed [OUT_W-1:0]    out_next;

    always_comb begin
        if (prod7_reg >= 0) begin
            core_w = (prod7_reg + (1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        end else begin
            core_w = -((-prod7_reg + (1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
        end
        core = val_t'(core_w);
        case (ctl_reg[NSTG-1].op)
            MODE_ELASTIC_IN:  ela = core;
            MODE_ELASTIC_OUT: ela = ONE_V - core;
            default:          ela = ctl_reg[NSTG-1].low ? half_rnd(core)
                                                        : ONE_V - half_rnd(core);
        endcase
        if (ctl_reg[NSTG-1].op inside {MODE_ELASTIC_IN, MODE_ELASTIC_OUT,
                                       MODE_ELASTIC_INOUT}) begin
            if (ctl_reg[NSTG-1].at_zero) begin
                fin = '0;
            end else if (ctl_reg[NSTG-1].at_one) begin
                fin = val_t'(ONE);
            end else begin
                fin = ela;
            end
        end else begin
            fin = res7_reg;
        end
        if (fin < -val_t'(ONE)) begin
            out_next = OUT_W'(-ONE);
        end else if (fin > val_t'(2 * ONE - 1)) begin
            out_next = OUT_W'(2 * ONE - 1);
        end else begin
            out_next = OUT_W'(fin);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign m_eased_value = out_reg;

endmodule

@@ bench/easing_curve_unit_tb.sv @@
module easing_curve_unit_tb
    import ecu_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // Fixed-point helpers for the easing predictor.
    localparam longint ONE_L = longint'(ONE);
    localparam longint NSEG = longint'(SEGS);
    localparam longint HPI = 64'sd1686629713;
    localparam longint LN2 = 64'sd744261118;

    function automatic longint rnd_shr(longint v, int s);
        longint h;
        h = 64'sd1 <<< (s - 1);
        if (v >= 0) begin
            return (v + h) >>> s;
        end
        return -(((-v) + h) >>> s);
    endfunction

    function automatic longint qmul(longint a, longint b);
        return rnd_shr(a * b, FRAC_BITS);
    endfunction

    function automatic longint q30_frac(longint v);
        longint r;
        r = rnd_shr(v, 30 - FRAC_BITS);
        return (r > ONE_L) ? ONE_L : r;
    endfunction

    // Quarter-wave sine entry from a truncated Taylor series.
    function automatic longint sine_entry(longint k);
        longint x;
        longint x2;
        longint term;
        longint sum;
        x = (k * HPI + NSEG / 2) >>> TABLE_ADDR_BITS;
        x2 = (x * x + (64'sd1 <<< 29)) >>> 30;
        term = x;
        sum = x;
        for (int n = 1; n <= 7; n++) begin
            term = ((term * x2) >>> 30) / longint'((2 * n) * (2 * n + 1));
            sum = (n % 2 == 1) ? sum - term : sum + term;
        end
        return q30_frac((sum < 0) ? 64'sd0 : sum);
    endfunction

    // Entry of 2^-x over one octave.
    function automatic longint octave_entry(longint k);
        longint y;
        longint term;
        longint sum;
        y = (k * LN2 + NSEG / 2) >>> TABLE_ADDR_BITS;
        term = 64'sd1 <<< 30;
        sum = term;
        for (int n = 1; n <= 12; n++) begin
            term = ((term * y) >>> 30) / longint'(n);
            sum = (n % 2 == 1) ? sum - term : sum + term;
        end
        return q30_frac((sum < 0) ? 64'sd0 : sum);
    endfunction

    // Linear interpolation between table entries.
    function automatic longint interp(bit use_exp, longint p);
        longint pos;
        longint k;
        longint fr;
        longint lo;
        longint hi;
        pos = p <<< TABLE_ADDR_BITS;
        k = pos >>> FRAC_BITS;
        fr = pos & (ONE_L - 1);
        if (k >= NSEG) begin
            k = NSEG - 1;
            fr = ONE_L;
        end
        lo = use_exp ? octave_entry(k) : sine_entry(k);
        hi = use_exp ? octave_entry(k + 1) : sine_entry(k + 1);
        return lo + rnd_shr((hi - lo) * fr, FRAC_BITS);
    endfunction

    // Sine of a phase given in quarter turns.
    function automatic longint sin_quarter(longint phase);
        longint ph;
        longint q;
        longint r;
        longint v;
        ph = phase & (4 * ONE_L - 1);
        q = ph >>> FRAC_BITS;
        r = ph & (ONE_L - 1);
        v = q[0] ? interp(1'b0, ONE_L - r) : interp(1'b0, r);
        return q[1] ? -v : v;
    endfunction

    function automatic longint pow2_neg(longint e);
        longint i;
        longint v;
        i = e >>> FRAC_BITS;
        v = interp(1'b1, e & (ONE_L - 1));
        if (i == 0) begin
            return v;
        end
        if (i > FRAC_BITS + 1) begin
            return 0;
        end
        return (v + ((64'sd1 <<< i) >>> 1)) >>> i;
    endfunction

    function automatic longint elastic_decay(longint d);
        return qmul(pow2_neg(10 * d), sin_quarter((40 * d + 1) / 3 + ONE_L));
    endfunction

    function automatic longint bounce(longint t);
        longint w;
        longint x;
        longint base;
        w = 11 * t;
        if (w < 4 * ONE_L) begin
            x = w;
            base = 0;
        end else if (w < 8 * ONE_L) begin
            x = w - 6 * ONE_L;
            base = 3 * ONE_L / 4;
        end else if (w < 10 * ONE_L) begin
            x = w - 9 * ONE_L;
            base = 15 * ONE_L / 16;
        end else begin
            x = w - 21 * ONE_L / 2;
            base = 63 * ONE_L / 64;
        end
        return base + ((x * x + (64'sd1 <<< (FRAC_BITS + 3))) >>> (FRAC_BITS + 4));
    endfunction

    // Full easing prediction including clamping and saturation.
    function automatic logic signed [OUT_W-1:0] eased_of(mode_t m, logic [PROG_W-1:0] p);
        longint t;
        longint d;
        longint v;
        bit lo;
        t = (longint'(p) > ONE_L) ? ONE_L : longint'(p);
        d = ONE_L - t;
        lo = t < ONE_L / 2;
        case (m)
            MODE_QUAD_IN: v = qmul(t, t);
            MODE_QUAD_OUT: v = qmul(t, 2 * ONE_L - t);
            MODE_QUAD_INOUT: v = lo ? 2 * qmul(t, t) : ONE_L - 2 * qmul(d, d);
            MODE_CUBIC_IN: v = qmul(qmul(t, t), t);
            MODE_CUBIC_OUT: v = ONE_L - qmul(qmul(d, d), d);
            MODE_CUBIC_INOUT: begin
                v = lo ? 4 * qmul(qmul(t, t), t) : ONE_L - 4 * qmul(qmul(d, d), d);
            end
            MODE_SINE_IN: v = ONE_L - sin_quarter(t + ONE_L);
            MODE_SINE_OUT: v = sin_quarter(t);
            MODE_SINE_INOUT: v = rnd_shr(ONE_L - sin_quarter(2 * t + ONE_L), 1);
            MODE_BOUNCE_IN: v = ONE_L - bounce(d);
            MODE_BOUNCE_OUT: v = bounce(t);
            MODE_BOUNCE_INOUT: begin
                v = lo ? rnd_shr(ONE_L - bounce(ONE_L - 2 * t), 1)
                       : rnd_shr(bounce(2 * t - ONE_L), 1) + ONE_L / 2;
            end
            MODE_ELASTIC_IN, MODE_ELASTIC_OUT, MODE_ELASTIC_INOUT: begin
                if (t == 0) begin
                    v = 0;
                end else if (t == ONE_L) begin
                    v = ONE_L;
                end else if (m == MODE_ELASTIC_IN) begin
                    v = elastic_decay(d);
                end else if (m == MODE_ELASTIC_OUT) begin
                    v = ONE_L - elastic_decay(t);
                end else begin
                    v = lo ? rnd_shr(elastic_decay(ONE_L - 2 * t), 1)
                           : ONE_L - rnd_shr(elastic_decay(2 * t - ONE_L), 1);
                end
            end
            default: v = t;
        endcase
        if (v < -ONE_L) begin
            v = -ONE_L;
        end
        if (v > 2 * ONE_L - 1) begin
            v = 2 * ONE_L - 1;
        end
        return OUT_W'(v);
    endfunction

    // Holds the eased values still owed by the block, in order.
    class eased_scoreboard;
        logic signed [OUT_W-1:0] pending[$];
        int errors;

        function void note_input(logic [3:0] op, logic [PROG_W-1:0] p);
            pending.push_back(eased_of(mode_t'(op), p));
        endfunction

        function void check_result(logic signed [OUT_W-1:0] got);
            logic signed [OUT_W-1:0] want;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %0d", $realtime, got);
                return;
            end
            want = pending.pop_front();
            if (want !== got) begin
                errors++;
                $display("%0t: eased_value expected %0d, actual %0d", $realtime, want, got);
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [3:0] s_operation = '0;
    logic [PROG_W-1:0] s_progress = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [OUT_W-1:0] m_eased_value;

    eased_scoreboard sb = new();
    bit quiet_run = 1'b0;
    longint cycles = 0;

    easing_curve_unit u_top (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 200000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver: random stalls except during the quiet stretch.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_eased_value);
        end
        m_ready <= quiet_run || ($urandom_range(99) >= 19);
    end

    // Present one item and hold it until the transfer happens.
    task automatic send_item(logic [3:0] op, logic [PROG_W-1:0] p);
        while (!quiet_run && $urandom_range(99) < 19) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_progress <= p;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        sb.note_input(op, p);
    endtask

    function automatic logic [PROG_W-1:0] random_progress();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0) begin
            return PROG_W'($urandom_range(ONE));
        end else if (sel == 1) begin
            return PROG_W'($urandom);
        end else if (sel == 2) begin
            return PROG_W'($urandom_range(3)) | PROG_W'(ONE * $urandom_range(1));
        end
        return PROG_W'($urandom_range(ONE - 1));
    endfunction

    logic [PROG_W-1:0] corner[7] = '{PROG_W'(0), PROG_W'(1), PROG_W'(ONE / 2 - 1),
                                     PROG_W'(ONE / 2), PROG_W'(ONE - 1), PROG_W'(ONE),
                                     '1};

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: each mode at one corner of progress, then end points and progress above one.
        for (int m = 0; m < 16; m++) begin
            send_item(4'(m), corner[m % 7]);
        end
        send_item(MODE_ELASTIC_INOUT, PROG_W'(0));
        send_item(MODE_ELASTIC_IN, PROG_W'(ONE));
        send_item(MODE_ELASTIC_OUT, '1);
        send_item(MODE_LINEAR, PROG_W'(ONE + 5));
        send_item(MODE_CUBIC_INOUT, PROG_W'(ONE / 2));
        s_valid <= 1'b0;

        // Sender waits until the pipeline has drained.
        while (sb.pending.size() != 0) begin
            @(posedge aclk);
        end

        for (int i = 0; i < 1830; i++) begin
            quiet_run = (i >= 600 && i < 800);
            send_item(4'($urandom_range(15)), random_progress());
        end
        quiet_run = 1'b0;
        s_valid <= 1'b0;

        while (sb.pending.size() != 0) begin
            @(posedge aclk);
        end
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
